@@ design/itrs_pkg.sv @@
// ----------------------------------------------------------------------------
// itrs_pkg
// Shared types, constants and helpers for the integer to radix string block.
// ----------------------------------------------------------------------------
package itrs_pkg;

	localparam int VALUE_BITS  = 32;
	localparam int RADIX_BITS  = 6;
	localparam int CHAR_BITS   = 8;

	// divider retires this many quotient bits per cycle
	localparam int DIV_BITS    = 8;
	localparam int DIV_CYCLES  = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
	localparam int PAD_BITS    = DIV_CYCLES * DIV_BITS;
	localparam int DCNT_BITS   = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

	// digit stack
	localparam int IDX_BITS    = $clog2(VALUE_BITS);
	localparam int CNT_BITS    = $clog2(VALUE_BITS + 1);

	localparam int QUEUE_DEPTH = 2;

	localparam logic [RADIX_BITS-1:0] RADIX_MIN = RADIX_BITS'(2);
	localparam logic [RADIX_BITS-1:0] RADIX_MAX = RADIX_BITS'(36);
	localparam logic [RADIX_BITS-1:0] DEC_DIGITS = RADIX_BITS'(10);

	localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_BITS-1:0] CHAR_UPPER = 8'h41;
	localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] value;
		logic [RADIX_BITS-1:0]        radix;
	} in_item_t;

	typedef struct packed {
		logic [CHAR_BITS-1:0] character;
		logic                 last;
	} out_item_t;

	// classified work for the back end
	typedef struct packed {
		logic                  neg;
		logic [VALUE_BITS-1:0] mag;
		logic [RADIX_BITS-1:0] radix;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_READ,
		ST_EMIT
	} back_state_t;

	typedef struct packed {
		logic pop;
		logic div_step;
		logic mem_rd;
		logic out_load;
		logic out_sign;
	} back_ctl_t;

	function automatic logic [CHAR_BITS-1:0] digit_char(input logic [RADIX_BITS-1:0] d);
		logic [CHAR_BITS-1:0] c;
		if (d < DEC_DIGITS) begin
			c = CHAR_ZERO + CHAR_BITS'(d);
		end else if (d < RADIX_MAX) begin
			c = CHAR_UPPER + CHAR_BITS'(d - DEC_DIGITS);
		end else begin
			c = CHAR_ZERO;
		end
		return c;
	endfunction

endpackage

@@ design/itrs_front.sv @@
// ----------------------------------------------------------------------------
// itrs_front
// Accepts items, splits sign and magnitude, clamps the radix and queues the
// job for the back end.
// ----------------------------------------------------------------------------
module itrs_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  itrs_pkg::in_item_t in_item,
	output logic               job_valid,
	output itrs_pkg::job_t     job,
	input  logic               job_pop
);

	localparam int PTR_BITS = (itrs_pkg::QUEUE_DEPTH > 1) ? $clog2(itrs_pkg::QUEUE_DEPTH) : 1;
	localparam int QCNT_BITS = $clog2(itrs_pkg::QUEUE_DEPTH + 1);

	itrs_pkg::job_t               queue_q [itrs_pkg::QUEUE_DEPTH];
	logic [PTR_BITS-1:0]          wr_ptr_q;
	logic [PTR_BITS-1:0]          rd_ptr_q;
	logic [QCNT_BITS-1:0]         count_q;
	itrs_pkg::job_t               job_in;
	logic                         push;
	logic                         pop;
	logic [itrs_pkg::VALUE_BITS-1:0] v;

	always_comb begin
		v            = in_item.value;
		job_in.neg   = v[itrs_pkg::VALUE_BITS-1];
		job_in.mag   = job_in.neg ? (~v + 1'b1) : v;
		if (in_item.radix < itrs_pkg::RADIX_MIN) begin
			job_in.radix = itrs_pkg::RADIX_MIN;
		end else if (in_item.radix > itrs_pkg::RADIX_MAX) begin
			job_in.radix = itrs_pkg::RADIX_MAX;
		end else begin
			job_in.radix = in_item.radix;
		end
	end

	assign in_ready  = count_q != QCNT_BITS'(itrs_pkg::QUEUE_DEPTH);
	assign job_valid = count_q != '0;
	assign job       = queue_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = job_pop && job_valid;

	function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
		logic [PTR_BITS-1:0] n;
		if (p == PTR_BITS'(itrs_pkg::QUEUE_DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + 1'b1;
		end
		return n;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= job_in;
		end
	end

endmodule

@@ design/itrs_back.sv @@
// ----------------------------------------------------------------------------
// itrs_back
// Repeated division by the radix into a digit stack, then emission of the
// sign and the digits, most significant first, through an output register.
// ----------------------------------------------------------------------------
module itrs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	input  itrs_pkg::job_t      job,
	output logic                job_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output itrs_pkg::out_item_t out_item
);

	itrs_pkg::back_state_t state_q, state_d;
	itrs_pkg::back_ctl_t   ctl;

	logic [itrs_pkg::PAD_BITS-1:0]   dq_q;
	logic [itrs_pkg::RADIX_BITS-1:0] rem_q;
	logic [itrs_pkg::RADIX_BITS-1:0] radix_q;
	logic                            neg_q;
	logic [itrs_pkg::DCNT_BITS-1:0]  dcnt_q;
	logic [itrs_pkg::CNT_BITS-1:0]   cnt_q;
	logic [itrs_pkg::RADIX_BITS-1:0] rd_q;
	logic [itrs_pkg::RADIX_BITS-1:0] digit_mem [itrs_pkg::VALUE_BITS];

	logic                            out_valid_q;
	itrs_pkg::out_item_t             out_q;

	logic [itrs_pkg::PAD_BITS-1:0]   dq_n;
	logic [itrs_pkg::RADIX_BITS-1:0] rem_n;
	logic [itrs_pkg::RADIX_BITS:0]   trial;
	logic                            div_last;
	logic                            div_finish;
	logic [itrs_pkg::CNT_BITS-1:0]   cnt_p1;
	logic [itrs_pkg::CNT_BITS-1:0]   cnt_m1;
	logic                            slot_free;

	// one chunk of restoring division, DIV_BITS quotient bits
	always_comb begin
		dq_n  = dq_q;
		rem_n = rem_q;
		trial = '0;
		for (int i = 0; i < itrs_pkg::DIV_BITS; i++) begin
			trial = {rem_n, dq_n[itrs_pkg::PAD_BITS-1]};
			dq_n  = dq_n << 1;
			if (trial >= {1'b0, radix_q}) begin
				trial   = trial - {1'b0, radix_q};
				dq_n[0] = 1'b1;
			end
			rem_n = trial[itrs_pkg::RADIX_BITS-1:0];
		end
	end

	assign div_last   = dcnt_q == itrs_pkg::DCNT_BITS'(itrs_pkg::DIV_CYCLES - 1);
	assign cnt_p1     = cnt_q + 1'b1;
	assign cnt_m1     = cnt_q - 1'b1;
	// stop when the quotient runs out or the stack is full
	assign div_finish = div_last &&
		(dq_n == '0 || cnt_p1 == itrs_pkg::CNT_BITS'(itrs_pkg::VALUE_BITS));
	assign slot_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			itrs_pkg::ST_IDLE: begin
				if (job_valid) begin
					state_d = itrs_pkg::ST_DIV;
				end
			end
			itrs_pkg::ST_DIV: begin
				if (div_finish) begin
					state_d = neg_q ? itrs_pkg::ST_SIGN : itrs_pkg::ST_READ;
				end
			end
			itrs_pkg::ST_SIGN: begin
				if (slot_free) begin
					state_d = itrs_pkg::ST_READ;
				end
			end
			itrs_pkg::ST_READ: begin
				state_d = itrs_pkg::ST_EMIT;
			end
			itrs_pkg::ST_EMIT: begin
				if (slot_free) begin
					state_d = (cnt_q == '0) ? itrs_pkg::ST_IDLE : itrs_pkg::ST_READ;
				end
			end
			default: begin
				state_d = itrs_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl = '0;
		case (state_q)
			itrs_pkg::ST_IDLE: begin
				ctl.pop = job_valid;
			end
			itrs_pkg::ST_DIV: begin
				ctl.div_step = 1'b1;
			end
			itrs_pkg::ST_SIGN: begin
				ctl.out_load = slot_free;
				ctl.out_sign = 1'b1;
			end
			itrs_pkg::ST_READ: begin
				ctl.mem_rd = 1'b1;
			end
			itrs_pkg::ST_EMIT: begin
				ctl.out_load = slot_free;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	assign job_pop = ctl.pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= itrs_pkg::ST_IDLE;
			dcnt_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.pop) begin
				dcnt_q <= '0;
				cnt_q  <= '0;
			end else if (ctl.div_step) begin
				if (div_last) begin
					dcnt_q <= '0;
					cnt_q  <= cnt_p1;
				end else begin
					dcnt_q <= dcnt_q + 1'b1;
				end
			end else if (ctl.mem_rd) begin
				cnt_q <= cnt_m1;
			end
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			dq_q    <= itrs_pkg::PAD_BITS'(job.mag);
			rem_q   <= '0;
			radix_q <= job.radix;
			neg_q   <= job.neg;
		end else if (ctl.div_step) begin
			dq_q  <= dq_n;
			rem_q <= div_last ? '0 : rem_n;
		end
		if (ctl.div_step && div_last) begin
			digit_mem[cnt_q[itrs_pkg::IDX_BITS-1:0]] <= rem_n;
		end
		if (ctl.mem_rd) begin
			rd_q <= digit_mem[cnt_m1[itrs_pkg::IDX_BITS-1:0]];
		end
		if (ctl.out_load) begin
			if (ctl.out_sign) begin
				out_q.character <= itrs_pkg::CHAR_MINUS;
				out_q.last      <= 1'b0;
			end else begin
				out_q.character <= itrs_pkg::digit_char(rd_q);
				out_q.last      <= cnt_q == '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

@@ design/integer_to_radix_string.sv @@
// ----------------------------------------------------------------------------
// integer_to_radix_string
// Converts a signed integer to its ASCII text in radix 2 to 36, one
// character per output item, most significant first, last one flagged.
//
//   channel  dir  handshake            payload
//   in       in   in_valid/in_ready    in_item  {value, radix}
//   out      out  out_valid/out_ready  out_item {character, last}
//
// The front end takes each item into a two-entry job queue.
// The back end takes one job at a time: it divides 8 quotient bits per cycle,
// pushing each remainder digit onto the digit stack, then emits the sign, if
// negative, and reads the digits back from the stack, one per output item.
// Reset is asynchronous; no clearing pass. A stalled output
// holds the back end while the front end keeps filling the queue.
// ----------------------------------------------------------------------------
module integer_to_radix_string (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  itrs_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output itrs_pkg::out_item_t out_item
);

	logic           job_valid;
	logic           job_pop;
	itrs_pkg::job_t job;

	itrs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop)
	);

	itrs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule
